// ----- hw/rtl/gci_pkg.sv -----
// shared types and constants for the grid colour interpolator
package gci_pkg;

    localparam int CW   = 12;   // pixel coordinate width
    localparam int DW   = 13;   // image dimension register width
    localparam int SZW  = 12;   // sector size width
    localparam int CHW  = 8;    // colour channel width
    localparam int RGBW = 3 * CHW;
    localparam int QDEPTH = 4;
    localparam int QAW  = 2;

    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_MODE   = 2'd2;

    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_PIXEL = 1'b1;

    localparam logic MODE_BILINEAR = 1'b0;
    localparam logic MODE_NEAREST  = 1'b1;

    typedef struct packed {
        logic            action;
        logic [3:0]      pidx;
        logic [RGBW-1:0] rgb;     // red in top byte, blue in low byte
        logic [3:0]      a_tl;
        logic [3:0]      a_tr;
        logic [3:0]      a_bl;
        logic [3:0]      a_br;
        logic [CW-1:0]   offx;
        logic [CW-1:0]   offy;
        logic            satx;
        logic            saty;
    } t_item;

    typedef struct packed {
        logic [SZW-1:0] sw;
        logic [SZW-1:0] sh;
        logic           mode;
    } t_cfg;

endpackage

// ----- hw/rtl/gci_front.sv -----
// front end: configuration registers, sector classification and item queue
module gci_front #(
    parameter int MAX_DIM = 4096
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [1:0]           i_cfg_index,
    input  logic [gci_pkg::DW-1:0] i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_action,
    input  logic [51:0]          i_data,
    output gci_pkg::t_cfg        o_cfg,
    output logic                 o_q_valid,
    output gci_pkg::t_item       o_q_item,
    input  logic                 i_pop
);

    localparam int SZW = gci_pkg::SZW;
    localparam int CW  = gci_pkg::CW;

    function automatic logic [SZW-1:0] sector_size(input logic [gci_pkg::DW-1:0] dim);
        logic [gci_pkg::DW-1:0] d;
        logic [28:0]            p;
        logic [SZW-1:0]         s;
        d = (32'(dim) > MAX_DIM) ? gci_pkg::DW'(MAX_DIM) : dim;
        // divide by three through the reciprocal, exact for 13-bit values
        p = 29'(d) * 29'(21846);
        s = SZW'(p >> 16);
        return (s == '0) ? SZW'(1) : s;
    endfunction

    logic [SZW-1:0] r_sw, r_sh, r_hw, r_hh;
    logic [SZW:0]   r_sw2, r_sh2, r_sw3, r_sh3;
    logic           r_mode;
    logic [SZW-1:0] n_sw, n_sh;

    logic [CW-1:0]  w_x, w_y;
    logic [1:0]     w_col, w_row, w_colr, w_rowb, w_nx, w_ny;
    logic [CW-1:0]  w_offx, w_offy;
    gci_pkg::t_item w_item;

    gci_pkg::t_item r_q [gci_pkg::QDEPTH];
    logic [gci_pkg::QAW-1:0] r_wp, r_rp;
    logic [gci_pkg::QAW:0]   r_cnt;
    logic w_push;

    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_sw = r_sw;
        n_sh = r_sh;
        if (!i_rst_n) begin
            n_sw = sector_size(gci_pkg::DW'(256));
            n_sh = sector_size(gci_pkg::DW'(256));
        end else if (i_cfg_valid && i_cfg_index == gci_pkg::CFG_WIDTH) begin
            n_sw = sector_size(i_cfg_data);
        end else if (i_cfg_valid && i_cfg_index == gci_pkg::CFG_HEIGHT) begin
            n_sh = sector_size(i_cfg_data);
        end
    end

    always_ff @(posedge i_clk) begin
        r_sw  <= n_sw;
        r_sh  <= n_sh;
        r_hw  <= n_sw >> 1;
        r_hh  <= n_sh >> 1;
        r_sw2 <= {n_sw, 1'b0};
        r_sh2 <= {n_sh, 1'b0};
        r_sw3 <= (SZW+1)'({n_sw, 1'b0}) + (SZW+1)'(n_sw);
        r_sh3 <= (SZW+1)'({n_sh, 1'b0}) + (SZW+1)'(n_sh);
        if (!i_rst_n) begin
            r_mode <= gci_pkg::MODE_BILINEAR;
        end else if (i_cfg_valid && i_cfg_index == gci_pkg::CFG_MODE) begin
            r_mode <= i_cfg_data[0];
        end
    end

    assign o_cfg = '{sw: r_sw, sh: r_sh, mode: r_mode};

    // sector column, offset and neighbours per axis
    always_comb begin
        w_x = i_data[39:28];
        w_y = i_data[51:40];
        if ((SZW+1)'(w_x) < (SZW+1)'(r_sw)) begin
            w_col = 2'd0; w_offx = w_x;
        end else if ((SZW+1)'(w_x) < r_sw2) begin
            w_col = 2'd1; w_offx = w_x - CW'(r_sw);
        end else if ((SZW+1)'(w_x) < r_sw3) begin
            w_col = 2'd2; w_offx = w_x - CW'(r_sw2);
        end else begin
            w_col = 2'd3; w_offx = w_x - CW'(r_sw3);
        end
        if ((SZW+1)'(w_y) < (SZW+1)'(r_sh)) begin
            w_row = 2'd0; w_offy = w_y;
        end else if ((SZW+1)'(w_y) < r_sh2) begin
            w_row = 2'd1; w_offy = w_y - CW'(r_sh);
        end else if ((SZW+1)'(w_y) < r_sh3) begin
            w_row = 2'd2; w_offy = w_y - CW'(r_sh2);
        end else begin
            w_row = 2'd3; w_offy = w_y - CW'(r_sh3);
        end
        w_colr = (w_col == 2'd3) ? 2'd3 : w_col + 2'd1;
        w_rowb = (w_row == 2'd3) ? 2'd3 : w_row + 2'd1;
        w_nx   = (w_offx <= r_hw) ? w_col : w_colr;
        w_ny   = (w_offy <= r_hh) ? w_row : w_rowb;

        w_item.action = i_action;
        w_item.pidx   = i_data[3:0];
        w_item.rgb    = {i_data[11:4], i_data[19:12], i_data[27:20]};
        w_item.a_tl   = (r_mode == gci_pkg::MODE_NEAREST) ? {w_ny, w_nx} : {w_row, w_col};
        w_item.a_tr   = {w_row, w_colr};
        w_item.a_bl   = {w_rowb, w_col};
        w_item.a_br   = {w_rowb, w_colr};
        w_item.offx   = w_offx;
        w_item.offy   = w_offy;
        w_item.satx   = (w_offx >= r_sw);
        w_item.saty   = (w_offy >= r_sh);
    end

    assign o_in_ready = (r_cnt != (gci_pkg::QAW+1)'(gci_pkg::QDEPTH));
    assign w_push     = i_in_valid && o_in_ready;
    assign o_q_valid  = (r_cnt != '0);
    assign o_q_item   = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_item;
        end
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            case ({w_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ----- hw/rtl/gci_back.sv -----
// back end: weight dividers, grid colour store, bilinear blend or nearest pick and output register
module gci_back #(
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  gci_pkg::t_cfg      i_cfg,
    input  logic               i_q_valid,
    input  gci_pkg::t_item     i_q_item,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [gci_pkg::RGBW-1:0] o_data
);

    localparam int F   = FRAC_BITS;
    localparam int WW  = F + 1;
    localparam int SZW = gci_pkg::SZW;
    localparam int CHW = gci_pkg::CHW;
    localparam int TW  = CHW + F + 1;
    localparam int AW  = TW + WW + 1;
    localparam logic [WW-1:0] ONE  = WW'(1) << F;
    localparam logic [AW-1:0] HALF = AW'(1) << (2 * F - 1);

    logic w_en;

    // divider pipeline, one quotient bit per stage
    logic           r_v   [F+1];
    gci_pkg::t_item r_it  [F+1];
    logic [SZW-1:0] r_rx  [F+1];
    logic [SZW-1:0] r_ry  [F+1];
    logic [F-1:0]   r_qx  [F+1];
    logic [F-1:0]   r_qy  [F+1];

    logic [gci_pkg::RGBW-1:0] r_mem_tl [16];
    logic [gci_pkg::RGBW-1:0] r_mem_tr [16];
    logic [gci_pkg::RGBW-1:0] r_mem_bl [16];
    logic [gci_pkg::RGBW-1:0] r_mem_br [16];

    logic                     r_av;
    logic [gci_pkg::RGBW-1:0] r_tl, r_tr, r_bl, r_br;
    logic [WW-1:0]            r_kx, r_ky;

    logic                     r_bv;
    logic [TW-1:0]            r_top [3];
    logic [TW-1:0]            r_bot [3];
    logic [WW-1:0]            r_bky;
    logic [gci_pkg::RGBW-1:0] r_bnn;
    logic [TW-1:0]            n_top [3];
    logic [TW-1:0]            n_bot [3];

    logic                     r_cv;
    logic [AW-1:0]            r_acc [3];
    logic [gci_pkg::RGBW-1:0] r_cnn;
    logic [AW-1:0]            n_acc [3];

    logic                     r_ov;
    logic [gci_pkg::RGBW-1:0] r_od;
    logic [gci_pkg::RGBW-1:0] n_od;

    assign w_en  = !r_ov || i_ready;
    assign o_pop = w_en && i_q_valid;

    always_ff @(posedge i_clk) begin
        logic [SZW:0] tx;
        logic [SZW:0] ty;
        if (w_en) begin
            r_it[0] <= i_q_item;
            r_rx[0] <= i_q_item.satx ? '0 : i_q_item.offx;
            r_ry[0] <= i_q_item.saty ? '0 : i_q_item.offy;
            r_qx[0] <= '0;
            r_qy[0] <= '0;
            for (int j = 0; j < F; j++) begin
                tx = {r_rx[j], 1'b0};
                ty = {r_ry[j], 1'b0};
                r_it[j+1] <= r_it[j];
                if (tx >= (SZW+1)'(i_cfg.sw)) begin
                    r_rx[j+1] <= SZW'(tx - (SZW+1)'(i_cfg.sw));
                    r_qx[j+1] <= {r_qx[j][F-2:0], 1'b1};
                end else begin
                    r_rx[j+1] <= SZW'(tx);
                    r_qx[j+1] <= {r_qx[j][F-2:0], 1'b0};
                end
                if (ty >= (SZW+1)'(i_cfg.sh)) begin
                    r_ry[j+1] <= SZW'(ty - (SZW+1)'(i_cfg.sh));
                    r_qy[j+1] <= {r_qy[j][F-2:0], 1'b1};
                end else begin
                    r_ry[j+1] <= SZW'(ty);
                    r_qy[j+1] <= {r_qy[j][F-2:0], 1'b0};
                end
            end
        end
        if (!i_rst_n) begin
            for (int j = 0; j <= F; j++) r_v[j] <= 1'b0;
        end else if (w_en) begin
            r_v[0] <= i_q_valid;
            for (int j = 0; j < F; j++) r_v[j+1] <= r_v[j];
        end
    end

    // colour store: four copies so each corner has its own read port
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (r_v[F] && r_it[F].action == gci_pkg::ACT_LOAD) begin
                r_mem_tl[r_it[F].pidx] <= r_it[F].rgb;
                r_mem_tr[r_it[F].pidx] <= r_it[F].rgb;
                r_mem_bl[r_it[F].pidx] <= r_it[F].rgb;
                r_mem_br[r_it[F].pidx] <= r_it[F].rgb;
            end
            r_tl <= r_mem_tl[r_it[F].a_tl];
            r_tr <= r_mem_tr[r_it[F].a_tr];
            r_bl <= r_mem_bl[r_it[F].a_bl];
            r_br <= r_mem_br[r_it[F].a_br];
            r_kx <= r_it[F].satx ? ONE : {1'b0, r_qx[F]};
            r_ky <= r_it[F].saty ? ONE : {1'b0, r_qy[F]};
        end
    end

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n_top[c] = TW'(r_tl[c*CHW +: CHW]) * TW'(ONE - r_kx)
                     + TW'(r_tr[c*CHW +: CHW]) * TW'(r_kx);
            n_bot[c] = TW'(r_bl[c*CHW +: CHW]) * TW'(ONE - r_kx)
                     + TW'(r_br[c*CHW +: CHW]) * TW'(r_kx);
            n_acc[c] = AW'(r_top[c]) * AW'(ONE - r_bky) + AW'(r_bot[c]) * AW'(r_bky);
            n_od[c*CHW +: CHW] = CHW'((r_acc[c] + HALF) >> (2 * F));
        end
        if (i_cfg.mode == gci_pkg::MODE_NEAREST) n_od = r_cnn;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_top <= n_top;
            r_bot <= n_bot;
            r_bky <= r_ky;
            r_bnn <= r_tl;
            r_acc <= n_acc;
            r_cnn <= r_bnn;
            r_od  <= n_od;
        end
        if (!i_rst_n) begin
            r_av <= 1'b0;
            r_bv <= 1'b0;
            r_cv <= 1'b0;
            r_ov <= 1'b0;
        end else if (w_en) begin
            r_av <= r_v[F] && r_it[F].action == gci_pkg::ACT_PIXEL;
            r_bv <= r_av;
            r_cv <= r_bv;
            r_ov <= r_cv;
        end
    end

    assign o_valid = r_ov;
    assign o_data  = r_od;

endmodule

// ----- hw/rtl/grid_color_interpolator_core.sv -----
// Grid colour interpolator: fills an image from a 4x4 grid of RGB control points.
// Input stream: tuser carries the action (load grid point or compute pixel),
// tdata the grid point index, its colour and the pixel coordinates.
// Output stream: one beat per pixel request with the interpolated colour;
// load beats produce no output.
// Configuration channel: index 0 image width, 1 image height, 2 mode
// (bilinear or nearest); write only while the block is idle.
// Throughput is one beat per cycle while the output is not stalled. From input
// beat to output beat the path runs through the queue, the weight dividers that
// resolve one quotient bit per pipeline stage, then store read, two multiply
// stages and the output register.
// A four-entry queue separates input from the back pipeline; the back pipeline
// and output register stall as a whole while a held output beat sees tready low,
// and the input side keeps accepting until the queue fills.
// Reset clears the pipeline and sets width and height to 256 and bilinear
// mode; grid colours are undefined until loaded.
module grid_color_interpolator_core #(
    parameter int MAX_DIM   = 4096,
    parameter int FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [12:0] i_cfg_data,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // point_index, red, green, blue, pixel_x, pixel_y, zero pad
    input  logic [55:0] i_s_axis_tdata,
    // action
    input  logic        i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // out_red, out_green, out_blue
    output logic [23:0] o_m_axis_tdata
);

    gci_pkg::t_cfg  w_cfg;
    gci_pkg::t_item w_q_item;
    logic           w_q_valid;
    logic           w_pop;

    gci_front #(.MAX_DIM(MAX_DIM)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .i_action    (i_s_axis_tuser),
        .i_data      (i_s_axis_tdata[51:0]),
        .o_cfg       (w_cfg),
        .o_q_valid   (w_q_valid),
        .o_q_item    (w_q_item),
        .i_pop       (w_pop)
    );

    gci_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (w_cfg),
        .i_q_valid (w_q_valid),
        .i_q_item  (w_q_item),
        .o_pop     (w_pop),
        .o_valid   (o_m_axis_tvalid),
        .i_ready   (i_m_axis_tready),
        .o_data    ({o_m_axis_tdata[7:0], o_m_axis_tdata[15:8], o_m_axis_tdata[23:16]})
    );

    // a full queue is never also reported as empty
    a_full_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> w_q_valid)
        else $error("queue reports full while empty");

    // no queue pop while the output is stalled
    a_no_pop_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |-> !w_pop)
        else $error("queue popped during output stall");

    // output is empty on the first cycle after reset
    a_reset_empty: assert property (@(posedge i_clk)
        (i_rst_n && $past(!i_rst_n)) |-> !o_m_axis_tvalid)
        else $error("output valid straight after reset");

endmodule
